// ===== hdl/assert_macros.svh =====
// assertion helpers for the point query pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication check failed");

// condition must never hold
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("forbidden condition seen");

`endif

// ===== hdl/nmq_pkg.sv =====
`timescale 1ns / 1ps
package nmq_pkg;

	localparam int CW    = 16;          // coordinate width, signed Q8.8
	localparam int IW    = 16;          // neighbour index width
	localparam int VW    = 3 * CW;      // packed vertex register width
	localparam int EW    = CW + 1;      // coordinate difference width
	localparam int PW    = 2 * EW;      // product of two differences
	localparam int DETW  = PW + 1;      // determinant and barycentric numerators
	localparam int NUMW  = DETW + EW + 1;
	localparam int TW    = CW + 3;      // ray top minus first vertex height
	localparam int LIMW  = DETW + TW;
	localparam int QW    = EW + 1;      // quotient bits, offset binary
	localparam int RW    = DETW + QW + 1;
	localparam int HW    = QW + 2;
	localparam int RAY_LIFT = 50 << 8;
	localparam int QOFS  = 1 << (QW - 1);
	localparam int HMAX  = (1 << (CW - 1)) - 1;
	localparam int HMIN  = -(1 << (CW - 1));

	typedef enum logic [2:0] {
		CFG_VERTEX_A    = 3'd0,
		CFG_VERTEX_B    = 3'd1,
		CFG_VERTEX_C    = 3'd2,
		CFG_NEIGHBOR_AB = 3'd3,
		CFG_NEIGHBOR_BC = 3'd4,
		CFG_NEIGHBOR_CA = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EDGE_AB = 2'd0,
		EDGE_BC = 2'd1,
		EDGE_CA = 2'd2
	} edge_t;

	// geometry held steady from configuration
	typedef struct packed {
		logic signed [CW-1:0]   ax, ay, az;
		logic signed [CW-1:0]   bx, bz;
		logic signed [CW-1:0]   cx, cz;
		logic signed [EW-1:0]   dx_ab, dy_ab, dz_ab;
		logic signed [EW-1:0]   dx_bc, dy_bc, dz_bc;
		logic signed [EW-1:0]   dx_ca, dy_ca, dz_ca;
		logic signed [EW-1:0]   e2x, e2y, e2z;
		logic signed [DETW-1:0] det;
		logic signed [CW+1:0]   ysum;
		logic signed [IW-1:0]   nb_ab, nb_bc, nb_ca;
	} geo_t;

	// per-item result fields travelling alongside the divider
	typedef struct packed {
		logic                 in_tri;
		edge_t                exit_edge;
		logic signed [IW-1:0] nb;
		logic                 blocked;
		logic signed [EW-1:0] ex, ey, ez;
		logic                 hit;
		logic                 below;
	} side_t;

endpackage

// ===== hdl/nmq_front.sv =====
`timescale 1ns / 1ps
module nmq_front import nmq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	input  logic signed [CW-1:0] pz,
	input  geo_t                 geo,
	output logic                 out_valid,
	output side_t                out_side,
	output logic [RW-1:0]        out_rem,
	output logic [DETW-1:0]      out_den
);

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [EW-1:0]   wxa_s1, wza_s1, wxb_s1, wzb_s1, wxc_s1, wzc_s1;
	logic signed [TW-1:0]   topm_s1, topm_s2, topm_s3;
	logic                   below_s1, below_s2, below_s3;
	logic signed [PW-1:0]   ta_s2, tb_s2, ua_s2, ub_s2, uc_s2, uds_s2;
	logic signed [PW-1:0]   p1_s2, p2_s2, p3_s2, p4_s2;
	logic [2:0]             cross_s3;
	logic signed [DETW-1:0] nu_s3, nv_s3, dabs_s3, dabs_s4;
	side_t                  side_s4, side_s5;
	logic                   ok_s4;
	logic signed [NUMW-2:0] m1_s4, m2_s4;
	logic signed [LIMW-1:0] lim_s4;
	logic [RW-1:0]          rem_s5;
	logic [DETW-1:0]        den_s5;

	logic signed [CW+1:0]   py3;
	logic signed [DETW-1:0] t0, t1, t2, nu_c, nv_c;
	logic signed [DETW:0]   uvsum;
	side_t                  side_c;
	side_t                  side5_c;
	logic signed [NUMW-1:0] num_c;
	logic signed [RW-1:0]   nsum_c;

	assign py3 = (CW+2)'(py) + (CW+2)'(py) + (CW+2)'(py);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: offsets from each vertex, ray top, average height flag
	always_ff @(posedge clk) begin
		wxa_s1   <= EW'(px) - EW'(geo.ax);
		wza_s1   <= EW'(pz) - EW'(geo.az);
		wxb_s1   <= EW'(px) - EW'(geo.bx);
		wzb_s1   <= EW'(pz) - EW'(geo.bz);
		wxc_s1   <= EW'(px) - EW'(geo.cx);
		wzc_s1   <= EW'(pz) - EW'(geo.cz);
		topm_s1  <= TW'(py) + TW'(RAY_LIFT) - TW'(geo.ay);
		below_s1 <= geo.ysum > py3;
	end

	// stage 2: edge test and barycentric products
	always_ff @(posedge clk) begin
		ta_s2    <= geo.dz_ab * wxa_s1;
		tb_s2    <= geo.dx_ab * wza_s1;
		ua_s2    <= geo.dz_bc * wxb_s1;
		ub_s2    <= geo.dx_bc * wzb_s1;
		uc_s2    <= geo.dz_ca * wxc_s1;
		uds_s2   <= geo.dx_ca * wzc_s1;
		p1_s2    <= wxa_s1 * geo.e2z;
		p2_s2    <= wza_s1 * geo.e2x;
		p3_s2    <= geo.dx_ab * wza_s1;
		p4_s2    <= geo.dz_ab * wxa_s1;
		topm_s2  <= topm_s1;
		below_s2 <= below_s1;
	end

	// stage 3: edge sums and sign-normalised numerators
	always_comb begin
		t0   = DETW'(tb_s2) - DETW'(ta_s2);
		t1   = DETW'(ub_s2) - DETW'(ua_s2);
		t2   = DETW'(uds_s2) - DETW'(uc_s2);
		nu_c = DETW'(p1_s2) - DETW'(p2_s2);
		nv_c = DETW'(p3_s2) - DETW'(p4_s2);
	end

	always_ff @(posedge clk) begin
		cross_s3 <= {t2 > 0, t1 > 0, t0 > 0};
		if (geo.det < 0) begin
			nu_s3   <= -nu_c;
			nv_s3   <= -nv_c;
			dabs_s3 <= -geo.det;
		end else begin
			nu_s3   <= nu_c;
			nv_s3   <= nv_c;
			dabs_s3 <= geo.det;
		end
		topm_s3  <= topm_s2;
		below_s3 <= below_s2;
	end

	// stage 4: exit edge choice, interpolation products, ray limit
	always_comb begin
		side_c           = '0;
		side_c.in_tri    = 1'b1;
		side_c.exit_edge = EDGE_AB;
		side_c.nb        = '1;
		side_c.below     = below_s3;
		if (cross_s3[0]) begin
			side_c.in_tri    = 1'b0;
			side_c.exit_edge = EDGE_AB;
			side_c.nb        = geo.nb_ab;
			side_c.blocked   = (geo.nb_ab == '1);
			if (side_c.blocked) begin
				side_c.ex = geo.dx_ab;
				side_c.ey = geo.dy_ab;
				side_c.ez = geo.dz_ab;
			end
		end else if (cross_s3[1]) begin
			side_c.in_tri    = 1'b0;
			side_c.exit_edge = EDGE_BC;
			side_c.nb        = geo.nb_bc;
			side_c.blocked   = (geo.nb_bc == '1);
			if (side_c.blocked) begin
				side_c.ex = geo.dx_bc;
				side_c.ey = geo.dy_bc;
				side_c.ez = geo.dz_bc;
			end
		end else if (cross_s3[2]) begin
			side_c.in_tri    = 1'b0;
			side_c.exit_edge = EDGE_CA;
			side_c.nb        = geo.nb_ca;
			side_c.blocked   = (geo.nb_ca == '1);
			if (side_c.blocked) begin
				side_c.ex = geo.dx_ca;
				side_c.ey = geo.dy_ca;
				side_c.ez = geo.dz_ca;
			end
		end
		uvsum = (DETW+1)'(nu_s3) + (DETW+1)'(nv_s3);
	end

	always_ff @(posedge clk) begin
		side_s4  <= side_c;
		ok_s4    <= (dabs_s3 != 0) && (nu_s3 >= 0) && (nv_s3 >= 0)
		            && (uvsum <= (DETW+1)'(dabs_s3));
		m1_s4    <= nu_s3 * geo.dy_ab;
		m2_s4    <= nv_s3 * geo.e2y;
		lim_s4   <= topm_s3 * dabs_s3;
		dabs_s4  <= dabs_s3;
	end

	// stage 5: hit decision and offset dividend for rounding to nearest
	always_comb begin
		num_c       = NUMW'(m1_s4) + NUMW'(m2_s4);
		nsum_c      = (RW'(num_c) <<< 1) + RW'(dabs_s4) + (RW'(dabs_s4) <<< QW);
		side5_c     = side_s4;
		side5_c.hit = ok_s4 && (LIMW'(num_c) <= lim_s4);
	end

	always_ff @(posedge clk) begin
		side_s5 <= side5_c;
		rem_s5  <= RW'(unsigned'(nsum_c));
		den_s5  <= DETW'(unsigned'(dabs_s4));
	end

	assign out_valid = v_s5;
	assign out_side  = side_s5;
	assign out_rem   = rem_s5;
	assign out_den   = den_s5;

endmodule

// ===== hdl/nmq_div.sv =====
`timescale 1ns / 1ps
module nmq_div import nmq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  side_t           in_side,
	input  logic [RW-1:0]   in_rem,
	input  logic [DETW-1:0] in_den,
	output logic            out_valid,
	output side_t           out_side,
	output logic [QW-1:0]   out_quot
);

	// one quotient bit per stage, most significant first; divisor is twice den
	logic            valid_s [QW];
	side_t           side_s  [QW];
	logic [RW-1:0]   rem_s   [QW];
	logic [DETW-1:0] den_s   [QW];
	logic [QW-1:0]   quot_s  [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic            v_in;
			side_t           s_in;
			logic [RW-1:0]   r_in;
			logic [DETW-1:0] d_in;
			logic [QW-1:0]   q_in;
			logic [RW-1:0]   dsh;
			logic            ge;

			if (k == 0) begin : g_first
				assign v_in = in_valid;
				assign s_in = in_side;
				assign r_in = in_rem;
				assign d_in = in_den;
				assign q_in = '0;
			end else begin : g_next
				assign v_in = valid_s[k-1];
				assign s_in = side_s[k-1];
				assign r_in = rem_s[k-1];
				assign d_in = den_s[k-1];
				assign q_in = quot_s[k-1];
			end

			// trial subtract against the shifted divisor
			assign dsh = RW'(d_in) << (QW - k);
			assign ge  = r_in >= dsh;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else begin
					valid_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				side_s[k] <= s_in;
				den_s[k]  <= d_in;
				rem_s[k]  <= ge ? (r_in - dsh) : r_in;
				quot_s[k] <= {q_in[QW-2:0], ge};
			end
		end
	endgenerate

	assign out_valid = valid_s[QW-1];
	assign out_side  = side_s[QW-1];
	assign out_quot  = quot_s[QW-1];

endmodule

// ===== hdl/navmesh_cell_point_query_core.sv =====
`timescale 1ns / 1ps
// done rises when a query taken with start has passed the front end, the divider and the output register
// throughput: one query per cycle while busy is low, through the 5-stage front end and 18-stage divider
// busy is high for one cycle after reset and after each register write, low otherwise
// the result receiver cannot stall, each result shows for one cycle
// reset: pipeline valid bits clear, vertices to zero, neighbours to -1 (wall)
module navmesh_cell_point_query_core import nmq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [VW-1:0]        cfg_wdata,
	input  logic signed [CW-1:0] pos_x,
	input  logic signed [CW-1:0] pos_y,
	input  logic signed [CW-1:0] pos_z,
	output logic                 done,
	output logic                 inside_res,
	output logic [1:0]           exit_edge,
	output logic signed [IW-1:0] neighbor_index,
	output logic                 blocked,
	output logic signed [EW-1:0] edge_dx,
	output logic signed [EW-1:0] edge_dy,
	output logic signed [EW-1:0] edge_dz,
	output logic                 height_hit,
	output logic signed [CW-1:0] surface_height,
	output logic                 below_average
);

`include "assert_macros.svh"

	logic [VW-1:0]        va_q, vb_q, vc_q;
	logic signed [IW-1:0] nab_q, nbc_q, nca_q;
	logic                 busy_q;
	geo_t                 geo_q;
	logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic signed [EW-1:0] e1x, e1z, e2x, e2z;
	logic signed [PW-1:0] dp1, dp2;

	logic                 fv;
	side_t                fside;
	logic [RW-1:0]        frem;
	logic [DETW-1:0]      fden;
	logic                 dv;
	side_t                dside;
	logic [QW-1:0]        dquot;
	logic signed [HW-1:0] hsum;
	logic signed [CW-1:0] hsat;

	// hold off queries while derived geometry catches up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= cfg_we;
		end
	end

	assign busy = busy_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q  <= '0;
			vb_q  <= '0;
			vc_q  <= '0;
			nab_q <= '1;
			nbc_q <= '1;
			nca_q <= '1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VERTEX_A:    va_q  <= cfg_wdata;
				CFG_VERTEX_B:    vb_q  <= cfg_wdata;
				CFG_VERTEX_C:    vc_q  <= cfg_wdata;
				CFG_NEIGHBOR_AB: nab_q <= cfg_wdata[IW-1:0];
				CFG_NEIGHBOR_BC: nbc_q <= cfg_wdata[IW-1:0];
				CFG_NEIGHBOR_CA: nca_q <= cfg_wdata[IW-1:0];
				default: ;
			endcase
		end
	end

	// derived geometry, refreshed every cycle
	always_comb begin
		ax  = va_q[CW-1:0];
		ay  = va_q[2*CW-1:CW];
		az  = va_q[3*CW-1:2*CW];
		bx  = vb_q[CW-1:0];
		by  = vb_q[2*CW-1:CW];
		bz  = vb_q[3*CW-1:2*CW];
		cx  = vc_q[CW-1:0];
		cy  = vc_q[2*CW-1:CW];
		cz  = vc_q[3*CW-1:2*CW];
		e1x = EW'(bx) - EW'(ax);
		e1z = EW'(bz) - EW'(az);
		e2x = EW'(cx) - EW'(ax);
		e2z = EW'(cz) - EW'(az);
		dp1 = e1x * e2z;
		dp2 = e1z * e2x;
	end

	always_ff @(posedge clk) begin
		geo_q.ax    <= ax;
		geo_q.ay    <= ay;
		geo_q.az    <= az;
		geo_q.bx    <= bx;
		geo_q.bz    <= bz;
		geo_q.cx    <= cx;
		geo_q.cz    <= cz;
		geo_q.dx_ab <= e1x;
		geo_q.dy_ab <= EW'(by) - EW'(ay);
		geo_q.dz_ab <= e1z;
		geo_q.dx_bc <= EW'(cx) - EW'(bx);
		geo_q.dy_bc <= EW'(cy) - EW'(by);
		geo_q.dz_bc <= EW'(cz) - EW'(bz);
		geo_q.dx_ca <= EW'(ax) - EW'(cx);
		geo_q.dy_ca <= EW'(ay) - EW'(cy);
		geo_q.dz_ca <= EW'(az) - EW'(cz);
		geo_q.e2x   <= e2x;
		geo_q.e2y   <= EW'(cy) - EW'(ay);
		geo_q.e2z   <= e2z;
		geo_q.det   <= DETW'(dp1) - DETW'(dp2);
		geo_q.ysum  <= (CW+2)'(ay) + (CW+2)'(by) + (CW+2)'(cy);
		geo_q.nb_ab <= nab_q;
		geo_q.nb_bc <= nbc_q;
		geo_q.nb_ca <= nca_q;
	end

	nmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.px        (pos_x),
		.py        (pos_y),
		.pz        (pos_z),
		.geo       (geo_q),
		.out_valid (fv),
		.out_side  (fside),
		.out_rem   (frem),
		.out_den   (fden)
	);

	nmq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fv),
		.in_side   (fside),
		.in_rem    (frem),
		.in_den    (fden),
		.out_valid (dv),
		.out_side  (dside),
		.out_quot  (dquot)
	);

	// height from offset quotient, saturated to the coordinate range
	always_comb begin
		hsum = HW'(geo_q.ay) + $signed(HW'(dquot)) - HW'(QOFS);
		if (hsum > HW'(HMAX)) begin
			hsat = CW'(HMAX);
		end else if (hsum < HW'(HMIN)) begin
			hsat = CW'(HMIN);
		end else begin
			hsat = hsum[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		inside_res     <= dside.in_tri;
		exit_edge      <= dside.exit_edge;
		neighbor_index <= dside.nb;
		blocked        <= dside.blocked;
		edge_dx        <= dside.ex;
		edge_dy        <= dside.ey;
		edge_dz        <= dside.ez;
		height_hit     <= dside.hit;
		surface_height <= dside.hit ? hsat : '0;
		below_average  <= dside.below;
	end

	`ASSERT_NEVER(a_blocked_inside, done && blocked && inside_res)
	`ASSERT_IMPL(a_inside_fields, done && inside_res, neighbor_index == '1 && exit_edge == EDGE_AB)
	`ASSERT_IMPL(a_miss_zero, done && !height_hit, surface_height == '0)
	`ASSERT_IMPL(a_open_edge, done && !blocked, edge_dx == '0 && edge_dy == '0 && edge_dz == '0)

endmodule
